@@ rtl/ipd_pkg.sv @@
// Package for the +IPD header parser: character codes, match positions, widths.
// No dependencies; used by the channel interfaces and the parser unit.
package ipd_pkg;

  localparam int LENGTH_WIDTH = 16;
  localparam int LINK_WIDTH   = 4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_I     = 8'h49;  // 'I'
  localparam logic [7:0] CH_P     = 8'h50;  // 'P'
  localparam logic [7:0] CH_D     = 8'h44;  // 'D'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    POS_IDLE  = 3'd0,
    POS_PLUS  = 3'd1,
    POS_I     = 3'd2,
    POS_P     = 3'd3,
    POS_D     = 3'd4,
    POS_ID    = 3'd5,
    POS_COMMA = 3'd6,
    POS_LEN   = 3'd7
  } pos_t;

  typedef struct packed {
    logic                    header_done;
    logic [LINK_WIDTH-1:0]   link_id;
    logic [LENGTH_WIDTH-1:0] payload_length;
  } res_t;

endpackage

@@ rtl/ipd_if.sv @@
// Valid/ready channel interfaces for the +IPD header parser.
// Depends on ipd_pkg for field widths.
interface ipd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ipd_out_if;
  logic                             valid;
  logic                             ready;
  logic                             header_done;
  logic [ipd_pkg::LINK_WIDTH-1:0]   link_id;
  logic [ipd_pkg::LENGTH_WIDTH-1:0] payload_length;

  modport source (output valid, output header_done, output link_id,
                  output payload_length, input ready);
  modport sink   (input valid, input header_done, input link_id,
                  input payload_length, output ready);
endinterface

@@ rtl/ipd_header_parser_unit.sv @@
// +IPD header parser: one received byte in, one result out per transaction.
// Each result is registered: in the result register, or in the skid register
// while a result waits. Throughput: one byte per cycle while the skid
// register is empty, so input keeps flowing while one result waits.
// Reset (synchronous, rst_n low): parser idle, link id and length cleared,
// both output registers empty.
module ipd_header_parser_unit (
  input  logic      clk,
  input  logic      rst_n,
  ipd_in_if.sink    in_ch,
  ipd_out_if.source out_ch
);
  import ipd_pkg::*;

  // parser state
  pos_t                    pos_r, pos_nxt;
  logic [LINK_WIDTH-1:0]   link_r, link_nxt;
  logic [LENGTH_WIDTH-1:0] acc_r, acc_nxt;
  logic                    stop_r, stop_nxt;

  // output side: result register and skid register
  res_t res_nxt;
  res_t out_r, skid_r;
  logic out_vld_r, skid_vld_r;

  logic       in_fire, out_fire;
  logic [7:0] c;
  logic       is_digit;
  logic [3:0] digit;
  logic [LENGTH_WIDTH+3:0] acc_x10;  // acc*10 + digit, before saturation

  assign c        = in_ch.rx_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit    = is_digit ? 4'(c - CH_ZERO) : 4'd0;
  // x10 as shift-and-add
  assign acc_x10  = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1)
                    + {{LENGTH_WIDTH{1'b0}}, digit};

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_vld_r & out_ch.ready;

  // skid free means there is always room for one more result
  assign in_ch.ready = ~skid_vld_r;

  // next match position
  always_comb begin
    pos_nxt = pos_r;
    unique case (pos_r)
      POS_IDLE:  if (c == CH_PLUS) pos_nxt = POS_PLUS;
      POS_PLUS:  pos_nxt = (c == CH_I) ? POS_I : POS_IDLE;
      POS_I:     pos_nxt = (c == CH_P) ? POS_P : POS_IDLE;
      POS_P:     pos_nxt = (c == CH_D) ? POS_D : POS_IDLE;
      POS_D:     pos_nxt = (c == CH_COMMA) ? POS_ID : POS_IDLE;
      POS_ID:    pos_nxt = POS_COMMA;
      POS_COMMA: pos_nxt = (c == CH_COMMA) ? POS_LEN : POS_IDLE;
      POS_LEN:   if (c == CH_COLON) pos_nxt = POS_IDLE;
      default:   pos_nxt = POS_IDLE;
    endcase
  end

  // datapath and result for this byte
  always_comb begin
    link_nxt = link_r;
    acc_nxt  = acc_r;
    stop_nxt = stop_r;
    res_nxt.header_done    = 1'b0;
    res_nxt.payload_length = '0;
    unique case (pos_r)
      POS_ID: begin
        link_nxt = digit;  // non-digit gives 0
      end
      POS_COMMA: begin
        // new header: clear length state
        if (c == CH_COMMA) begin
          acc_nxt  = '0;
          stop_nxt = 1'b0;
        end
      end
      POS_LEN: begin
        if (c == CH_COLON) begin
          res_nxt.header_done    = 1'b1;
          res_nxt.payload_length = acc_r;
        end else if (is_digit && !stop_r) begin
          // saturate at all ones
          if (acc_x10 > {4'd0, LEN_MAX}) begin
            acc_nxt = LEN_MAX;
          end else begin
            acc_nxt = acc_x10[LENGTH_WIDTH-1:0];
          end
        end else begin
          stop_nxt = 1'b1;  // stray byte ends the digits, as atoi would
        end
      end
      default: begin
      end
    endcase
    res_nxt.link_id = link_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_IDLE;
      link_r <= '0;
      acc_r  <= '0;
      stop_r <= 1'b0;
    end else if (in_fire) begin
      pos_r  <= pos_nxt;
      link_r <= link_nxt;
      acc_r  <= acc_nxt;
      stop_r <= stop_nxt;
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (out_fire) begin
          out_r      <= skid_r;
          skid_vld_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_vld_r || out_fire) begin
          out_r     <= res_nxt;
          out_vld_r <= 1'b1;
        end else begin
          skid_r     <= res_nxt;
          skid_vld_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.header_done    = out_r.header_done;
  assign out_ch.link_id        = out_r.link_id;
  assign out_ch.payload_length = out_r.payload_length;

endmodule
